FILE: src/cssp_pkg.sv
// Package for the CPU state share block: widths, constants and the
// command/status types shared by the controller and the datapath.
`timescale 1ns / 1ps

package cssp_pkg;

    localparam int NUM_STATES = 5;
    localparam int TICK_W     = 64;
    localparam int SHARE_W    = 10;
    localparam int IDX_W      = $clog2(NUM_STATES);
    localparam int TOTAL_W    = TICK_W + $clog2(NUM_STATES);
    localparam int NUM_W      = TOTAL_W + SHARE_W;
    localparam int CNT_W      = $clog2(SHARE_W);

    // 1000 = 1024 - 32 + 8
    localparam int PM_SH_HI  = 10;
    localparam int PM_SH_MID = 5;
    localparam int PM_SH_LO  = 3;

    typedef logic [NUM_STATES-1:0][TICK_W-1:0]  tick_vec_t;
    typedef logic [NUM_STATES-1:0][SHARE_W-1:0] share_vec_t;

    typedef struct packed {
        logic             load;
        logic             sum_en;
        logic             fix_total;
        logic             num_init;
        logic             num_add_lo;
        logic             num_add_half;
        logic             div_step;
        logic             div_last;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic total_zero;
    } dp_status_t;

endpackage

FILE: src/cssp_datapath.sv
// Datapath: snapshot store, differences, wide total, per-mille scaling and
// a shared restoring divider. Depends on cssp_pkg.
`timescale 1ns / 1ps

module cssp_datapath
    import cssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tick_vec_t  ticks,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output share_vec_t share
);

    tick_vec_t           prev_reg;
    tick_vec_t           diff_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    div_reg;
    logic [SHARE_W-1:0]  quo_reg;
    share_vec_t          share_reg;
    share_vec_t          out_share_reg;

    logic [NUM_W-1:0]    diff_ext;
    logic [NUM_W-1:0]    half_ext;
    logic                rem_ge;
    logic [SHARE_W-1:0]  quo_next;

    assign diff_ext = NUM_W'(diff_reg[cmd.idx]);
    assign half_ext = NUM_W'(total_reg >> 1);
    assign rem_ge   = (num_reg >= div_reg);
    assign quo_next = {quo_reg[SHARE_W-2:0], rem_ge};

    assign status.total_zero = (total_reg == '0);
    assign share             = out_share_reg;

    // Stored snapshot: the only state that a later transaction reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
        end
        else if (cmd.load)
        begin
            prev_reg <= ticks;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                diff_reg[i] <= ticks[i] - prev_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            total_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            total_reg <= total_reg + TOTAL_W'(diff_reg[cmd.idx]);
        end
        else if (cmd.fix_total)
        begin
            total_reg <= TOTAL_W'(1);
        end
    end

    // Numerator diff*1000 + total/2, built by shift-and-add over three steps
    always_ff @(posedge clk)
    begin
        if (cmd.num_init)
        begin
            num_reg <= (diff_ext << PM_SH_HI) - (diff_ext << PM_SH_MID);
            div_reg <= NUM_W'(total_reg) << (SHARE_W - 1);
            quo_reg <= '0;
        end
        else if (cmd.num_add_lo)
        begin
            num_reg <= num_reg + (diff_ext << PM_SH_LO);
        end
        else if (cmd.num_add_half)
        begin
            num_reg <= num_reg + half_ext;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                num_reg <= num_reg - div_reg;
            end
            div_reg <= div_reg >> 1;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && cmd.div_last)
        begin
            share_reg[cmd.idx] <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_share_reg <= share_reg;
        end
    end

endmodule

FILE: src/cssp_ctrl.sv
// Controller: sequences accept, summation, scaling and division per state,
// and owns both handshakes. Depends on cssp_pkg.
`timescale 1ns / 1ps

module cssp_ctrl
    import cssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SUM   = 3'd1;
    localparam logic [2:0] S_FIX   = 3'd2;
    localparam logic [2:0] S_MUL_A = 3'd3;
    localparam logic [2:0] S_MUL_B = 3'd4;
    localparam logic [2:0] S_MUL_C = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_STATES - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SHARE_W - 1);

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.idx        = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_FIX;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FIX:
            begin
                cmd.fix_total = status.total_zero;
                state_next    = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.num_init = 1'b1;
                state_next   = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.num_add_lo = 1'b1;
                state_next     = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.num_add_half = 1'b1;
                cnt_next         = '0;
                state_next       = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cmd.div_last = 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_MUL_A;
                    end
                end
            end
            S_DONE:
            begin
                // hold the finished shares until the output register frees up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/cpu_state_share_per_mille_top.sv
// Top level of the CPU state share block: ties the controller to the
// datapath and maps the fields onto ports. Depends on cssp_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | ticks_* (5 x 64-bit counters)
//   out     | output    | out_valid/out_stall| share_* (5 x 10-bit per-mille)
//
// One transaction runs from accept through summation, the zero-total fix,
// scaling and a divide for each state in turn, and the output load. The
// 10-step restoring divider is shared by all five states; a new transaction
// is accepted on the next cycle after the output load.
// Reset clears the stored snapshot to zero and the control to idle.
// A stalled result holds in the output register while the next transaction
// is accepted and worked; only the final load waits for the register to free.
`timescale 1ns / 1ps

module cpu_state_share_per_mille_top
    import cssp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TICK_W-1:0]   ticks_user,
    input  logic [TICK_W-1:0]   ticks_nice,
    input  logic [TICK_W-1:0]   ticks_system,
    input  logic [TICK_W-1:0]   ticks_interrupt,
    input  logic [TICK_W-1:0]   ticks_idle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [SHARE_W-1:0]  share_user,
    output logic [SHARE_W-1:0]  share_nice,
    output logic [SHARE_W-1:0]  share_system,
    output logic [SHARE_W-1:0]  share_interrupt,
    output logic [SHARE_W-1:0]  share_idle
);

    tick_vec_t  ticks;
    share_vec_t share;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Gather the counters in state order: user, nice, system, interrupt, idle
    assign ticks[0] = ticks_user;
    assign ticks[1] = ticks_nice;
    assign ticks[2] = ticks_system;
    assign ticks[3] = ticks_interrupt;
    assign ticks[4] = ticks_idle;

    assign share_user      = share[0];
    assign share_nice      = share[1];
    assign share_system    = share[2];
    assign share_interrupt = share[3];
    assign share_idle      = share[4];

    // Sequence the work and own both handshakes
    cssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the snapshot, form differences and total, divide per state
    cssp_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ticks  (ticks),
        .cmd    (cmd),
        .status (status),
        .share  (share)
    );

endmodule

FILE: src/cssp_checker.sv
// Port-level checker for the CPU state share block, bound to the top level.
// Depends on cssp_pkg.
`timescale 1ns / 1ps

module cssp_checker
    import cssp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [SHARE_W-1:0] share_user,
    input logic [SHARE_W-1:0] share_idle
);

    localparam logic [SHARE_W-1:0] SHARE_MAX = SHARE_W'(1000);

    // A result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(share_user))
        else $error("result dropped or changed while stalled");

    // Accepting a transaction makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block not busy after accept");

    // A new result appears only at the end of work on a transaction
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a transaction in work");

    // The user and idle shares never exceed one thousand per-mille
    a_share_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (share_user <= SHARE_MAX) && (share_idle <= SHARE_MAX))
        else $error("share out of range");

endmodule

bind cpu_state_share_per_mille_top cssp_checker u_cssp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .share_user (share_user),
    .share_idle (share_idle)
);
